// ----- sv/assert_macros.svh -----
// assertion macros used by the rtl top level
// needs a clock named clock and an active-high reset named reset in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define TXDQ_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("txdq check failed");

// next-cycle implication
`define TXDQ_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("txdq check failed");

`endif

// ----- sv/txdq_pkg.sv -----
// types and constants of the transmit descriptor queue
// no dependencies
`default_nettype none

package txdq_pkg;

   localparam logic [15:0] BUDGET_RESET = 16'd5520;
   localparam logic [15:0] CREDIT_MAX   = 16'hFFFF;

   localparam logic [1:0] MODE_WRITE = 2'd0;
   localparam logic [1:0] MODE_DONE  = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;
   localparam logic [1:0] MODE_NONE  = 2'd3;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_REFUSED   = 3'd1;
   localparam logic [2:0] ST_OCCUPIED  = 3'd2;
   localparam logic [2:0] ST_FREE_FAIL = 3'd3;
   localparam logic [2:0] ST_BAD_PORT  = 3'd4;
   localparam logic [2:0] ST_CLEARED   = 3'd5;

   typedef struct packed {
      logic [1:0]  mode;
      logic [1:0]  port;
      logic [15:0] packet_size;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [8:0]  queue_count;
      logic        start_valid;
      logic [1:0]  start_port;
      logic [15:0] start_size;
      logic        sent_event;
      logic        link_idle;
      logic [15:0] credit_left;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_WRITE,
      S_FREE_RD,
      S_FREE,
      S_NEXT,
      S_CLR_WALK,
      S_CLR_LAST,
      S_RESP
   } state_type;

   typedef enum logic {
      ALU_SUB,
      ALU_ADD_SAT
   } alu_op_type;

   typedef struct packed {
      logic [15:0] value;
      logic        not_positive;
   } alu_res_type;

   typedef struct packed {
      logic wr;
      logic rd;
      logic free;
   } ring_ctl_type;

endpackage

`default_nettype wire

// ----- sv/tx_descriptor_queue_with_byte_credit.sv -----
// transmit descriptor queue with byte credit, top level
// depends on txdq_pkg, txdq_credit_alu, txdq_ring and assert_macros.svh
//
// usage
//  - command channel: present req_item and raise start; the command is taken
//    at a clock edge with start high and busy low. mode selects a write
//    request, a transfer completion or a clear of the whole ring
//  - result channel: exactly one result per command, shown on rsp_item for
//    a single cycle with rsp_strobe high; the receiver cannot stall it, so
//    it must capture the result in that cycle
//  - csr_write_en/csr_write_data load the byte budget straight into the
//    remaining credit; write only while busy is low and no result is due
//  - a write steps through S_WRITE, a completion through S_FREE_RD, then
//    S_FREE unless the slot is empty, then S_NEXT if the next queued
//    descriptor is started, a clear through S_CLR_WALK for every slot and
//    S_CLR_LAST; every command, an unused mode at once, ends in S_RESP.
//    Completion and clear share the one registered read port of the ring
//    memory; the single credit unit charges or returns bytes once a cycle
//  - busy is low again in the cycle the strobe shows, so a new command can
//    follow the result at once
//  - reset clears the occupied flags, indices, count, sets the link idle
//    and loads the credit with 5520; port/size storage is not cleared
`default_nettype none

module tx_descriptor_queue_with_byte_credit #(
   parameter int QUEUE_DEPTH = 16
) (
   input  var logic              clock,
   input  var logic              reset,
   input  var logic              start,
   output var logic              busy,
   input  var txdq_pkg::req_type req_item,
   output var logic              rsp_strobe,
   output var txdq_pkg::rsp_type rsp_item,
   input  var logic              csr_write_en,
   input  var logic [15:0]       csr_write_data
);
   import txdq_pkg::*;

`include "assert_macros.svh"

   localparam int IDXW = $clog2(QUEUE_DEPTH);
   localparam logic [IDXW-1:0] LAST_IDX = IDXW'(QUEUE_DEPTH - 1);
   localparam logic [8:0]      DEPTH_CNT = 9'(QUEUE_DEPTH);

   function automatic logic [IDXW-1:0] ring_next(input logic [IDXW-1:0] idx);
      ring_next = (idx == LAST_IDX) ? '0 : idx + 1'b1;
   endfunction

   // control state
   state_type       state_ff, state_in;
   logic [IDXW-1:0] head_ff, head_in;
   logic [IDXW-1:0] tail_ff, tail_in;
   logic [8:0]      held_ff, held_in;
   logic [15:0]     credit_ff, credit_in;
   logic            idle_ff, idle_in;
   logic            pend_ff, pend_in;
   logic            rsp_valid_ff, rsp_valid_in;

   // per-command working registers
   req_type         item_ff, item_in;
   logic [2:0]      status_ff, status_in;
   logic            sv_ff, sv_in;
   logic [1:0]      sp_ff, sp_in;
   logic [15:0]     ss_ff, ss_in;
   logic            sent_ff, sent_in;
   logic [IDXW-1:0] walk_ff, walk_in;
   logic [IDXW-1:0] prev_ff, prev_in;
   rsp_type         rsp_ff, rsp_in;

   // shared unit and ring wiring
   alu_op_type       alu_op;
   logic [15:0]      alu_operand;
   alu_res_type      alu_res;
   ring_ctl_type     ring_ctl;
   logic [IDXW-1:0]  rd_addr;
   logic [IDXW-1:0]  free_addr;
   logic [1:0]       rd_port;
   logic [15:0]      rd_size;
   logic [QUEUE_DEPTH-1:0] occupied;
   logic [8:0]       held_dec;

   txdq_credit_alu u_alu (
      .op      (alu_op),
      .credit  (credit_ff),
      .operand (alu_operand),
      .result  (alu_res)
   );

   txdq_ring #(
      .DEPTH (QUEUE_DEPTH),
      .IDXW  (IDXW)
   ) u_ring (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ring_ctl),
      .wr_addr   (head_ff),
      .wr_port   (item_ff.port),
      .wr_size   (item_ff.packet_size),
      .rd_addr   (rd_addr),
      .free_addr (free_addr),
      .rd_port   (rd_port),
      .rd_size   (rd_size),
      .occupied  (occupied)
   );

   // count after a completion frees a slot, never below zero
   assign held_dec = (held_ff != 9'd0) ? held_ff - 9'd1 : 9'd0;

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      held_in      = held_ff;
      credit_in    = credit_ff;
      idle_in      = idle_ff;
      pend_in      = pend_ff;
      rsp_valid_in = 1'b0;
      item_in      = item_ff;
      status_in    = status_ff;
      sv_in        = sv_ff;
      sp_in        = sp_ff;
      ss_in        = ss_ff;
      sent_in      = sent_ff;
      walk_in      = walk_ff;
      prev_in      = prev_ff;
      rsp_in       = rsp_ff;
      alu_op       = ALU_SUB;
      alu_operand  = item_ff.packet_size;
      ring_ctl     = '0;
      rd_addr      = tail_ff;
      free_addr    = tail_ff;

      unique case (state_ff)
         S_IDLE: begin
            status_in = ST_OK;
            sv_in     = 1'b0;
            sp_in     = 2'd0;
            ss_in     = 16'd0;
            sent_in   = 1'b0;
            if (csr_write_en) begin
               credit_in = csr_write_data;
            end
            if (start) begin
               item_in = req_item;
               unique case (req_item.mode)
                  MODE_WRITE: state_in = S_WRITE;
                  MODE_DONE:  state_in = S_FREE_RD;
                  MODE_CLEAR: begin
                     state_in = S_CLR_WALK;
                     walk_in  = '0;
                     pend_in  = 1'b0;
                     held_in  = 9'd0;
                  end
                  default:    state_in = S_RESP;
               endcase
            end
         end

         S_WRITE: begin
            // unless full or out of credit, charge the credit, then enqueue at head if the slot is free
            if ((held_ff >= DEPTH_CNT) || alu_res.not_positive) begin
               status_in = ST_REFUSED;
            end else begin
               credit_in = alu_res.value;
               if (occupied[head_ff]) begin
                  status_in = ST_OCCUPIED;
               end else begin
                  ring_ctl.wr = 1'b1;
                  held_in     = held_ff + 9'd1;
                  head_in     = ring_next(head_ff);
                  if (idle_ff) begin
                     if (item_ff.port != 2'd0) begin
                        sv_in   = 1'b1;
                        sp_in   = item_ff.port;
                        ss_in   = item_ff.packet_size;
                        idle_in = 1'b0;
                     end else begin
                        status_in = ST_BAD_PORT;
                     end
                  end
               end
            end
            state_in = S_RESP;
         end

         S_FREE_RD: begin
            if (occupied[tail_ff]) begin
               ring_ctl.rd = 1'b1;
               state_in    = S_FREE;
            end else begin
               status_in = ST_FREE_FAIL;
               tail_in   = ring_next(tail_ff);
               state_in  = S_RESP;
            end
         end

         S_FREE: begin
            // return the bytes of the finished descriptor
            alu_op        = ALU_ADD_SAT;
            alu_operand   = rd_size;
            credit_in     = alu_res.value;
            held_in       = held_dec;
            ring_ctl.free = 1'b1;
            tail_in       = ring_next(tail_ff);
            sent_in       = 1'b1;
            if (held_dec != 9'd0) begin
               ring_ctl.rd = 1'b1;
               rd_addr     = ring_next(tail_ff);
               state_in    = S_NEXT;
            end else begin
               idle_in  = 1'b1;
               state_in = S_RESP;
            end
         end

         S_NEXT: begin
            sv_in    = 1'b1;
            sp_in    = rd_port;
            ss_in    = rd_size;
            state_in = S_RESP;
         end

         S_CLR_WALK: begin
            // read one slot a cycle, settle the slot read the cycle before
            ring_ctl.rd = 1'b1;
            rd_addr     = walk_ff;
            prev_in     = walk_ff;
            pend_in     = 1'b1;
            free_addr   = prev_ff;
            if (pend_ff && occupied[prev_ff]) begin
               alu_op        = ALU_ADD_SAT;
               alu_operand   = rd_size;
               credit_in     = alu_res.value;
               ring_ctl.free = 1'b1;
            end
            if (walk_ff == LAST_IDX) begin
               state_in = S_CLR_LAST;
            end else begin
               walk_in = walk_ff + 1'b1;
            end
         end

         S_CLR_LAST: begin
            free_addr = prev_ff;
            if (occupied[prev_ff]) begin
               alu_op        = ALU_ADD_SAT;
               alu_operand   = rd_size;
               credit_in     = alu_res.value;
               ring_ctl.free = 1'b1;
            end
            head_in   = '0;
            tail_in   = '0;
            status_in = ST_CLEARED;
            state_in  = S_RESP;
         end

         S_RESP: begin
            rsp_valid_in       = 1'b1;
            rsp_in.status      = status_ff;
            rsp_in.queue_count = held_ff;
            rsp_in.start_valid = sv_ff;
            rsp_in.start_port  = sp_ff;
            rsp_in.start_size  = ss_ff;
            rsp_in.sent_event  = sent_ff;
            rsp_in.link_idle   = idle_ff;
            rsp_in.credit_left = credit_ff;
            state_in           = S_IDLE;
         end

         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         held_ff      <= 9'd0;
         credit_ff    <= BUDGET_RESET;
         idle_ff      <= 1'b1;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         held_ff      <= held_in;
         credit_ff    <= credit_in;
         idle_ff      <= idle_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      status_ff <= status_in;
      sv_ff     <= sv_in;
      sp_ff     <= sp_in;
      ss_ff     <= ss_in;
      sent_ff   <= sent_in;
      walk_ff   <= walk_in;
      prev_ff   <= prev_in;
      rsp_ff    <= rsp_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_valid_ff;
   assign rsp_item   = rsp_ff;

   // checks
   `TXDQ_ASSERT_NOW(a_rsp_when_ready, rsp_strobe, !busy)
   `TXDQ_ASSERT_NEXT(a_accept_goes_busy, start && !busy, busy)
   `TXDQ_ASSERT_NOW(a_held_in_range, 1'b1, held_ff <= DEPTH_CNT)
   `TXDQ_ASSERT_NOW(a_sent_is_ok, rsp_strobe && rsp_item.sent_event, rsp_item.status == ST_OK)

endmodule

`default_nettype wire

// ----- sv/txdq_credit_alu.sv -----
// shared credit unit: charge with sign check, or saturating return
// depends on txdq_pkg
`default_nettype none

module txdq_credit_alu (
   input  var txdq_pkg::alu_op_type  op,
   input  var logic [15:0]           credit,
   input  var logic [15:0]           operand,
   output var txdq_pkg::alu_res_type result
);
   import txdq_pkg::*;

   logic [16:0] diff;
   logic [16:0] sum;

   assign diff = {1'b0, credit} - {1'b0, operand};
   assign sum  = {1'b0, credit} + {1'b0, operand};

   always_comb begin
      result = '0;
      unique case (op)
         ALU_SUB: begin
            // difference at or below zero refuses the charge
            result.value        = diff[15:0];
            result.not_positive = diff[16] | (diff[15:0] == 16'd0);
         end
         ALU_ADD_SAT: begin
            result.value        = sum[16] ? CREDIT_MAX : sum[15:0];
            result.not_positive = 1'b0;
         end
         default: result = '0;
      endcase
   end

endmodule

`default_nettype wire

// ----- sv/txdq_ring.sv -----
// descriptor ring storage: port/size memory and occupied flags
// depends on txdq_pkg
`default_nettype none

module txdq_ring #(
   parameter int DEPTH = 16,
   parameter int IDXW  = $clog2(DEPTH)
) (
   input  var logic                   clock,
   input  var logic                   reset,
   input  var txdq_pkg::ring_ctl_type ctl,
   input  var logic [IDXW-1:0]        wr_addr,
   input  var logic [1:0]             wr_port,
   input  var logic [15:0]            wr_size,
   input  var logic [IDXW-1:0]        rd_addr,
   input  var logic [IDXW-1:0]        free_addr,
   output var logic [1:0]             rd_port,
   output var logic [15:0]            rd_size,
   output var logic [DEPTH-1:0]       occupied
);
   import txdq_pkg::*;

   logic [1:0]  port_mem [DEPTH];
   logic [15:0] size_mem [DEPTH];
   logic [DEPTH-1:0] occ_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr) begin
         port_mem[wr_addr] <= wr_port;
         size_mem[wr_addr] <= wr_size;
      end
      if (ctl.rd) begin
         rd_port <= port_mem[rd_addr];
         rd_size <= size_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         if (ctl.wr) begin
            occ_ff[wr_addr] <= 1'b1;
         end
         if (ctl.free) begin
            occ_ff[free_addr] <= 1'b0;
         end
      end
   end

   assign occupied = occ_ff;

endmodule

`default_nettype wire

// ----- bench/tx_descriptor_queue_with_byte_credit_tb.sv -----
// testbench for the transmit descriptor queue with byte credit
// self-checking: a scoreboard class predicts every result from the commands it sees
// depends on txdq_pkg and the rtl top level tx_descriptor_queue_with_byte_credit
`timescale 1ns / 100ps

module tx_descriptor_queue_with_byte_credit_tb;
   import txdq_pkg::*;

   localparam int QUEUE_DEPTH  = 16;
   localparam int RANDOM_ITEMS = 1950;
   localparam int PHASES       = 12;

   // ring predictor and store of outstanding results
   class descriptor_ring_scoreboard;
      bit          slot_held    [QUEUE_DEPTH];
      bit          slot_written [QUEUE_DEPTH];
      logic [1:0]  slot_port    [QUEUE_DEPTH];
      logic [15:0] slot_len     [QUEUE_DEPTH];
      int          head;
      int          tail;
      int          held;
      int          credit;
      bit          idle;
      rsp_type     due_results [$];
      int          fails;
      int          checked;
      int          status_seen [8];

      function new();
         foreach (slot_held[i]) begin
            slot_held[i]    = 1'b0;
            slot_written[i] = 1'b0;
            slot_port[i]    = '0;
            slot_len[i]     = '0;
         end
         foreach (status_seen[i]) status_seen[i] = 0;
         head    = 0;
         tail    = 0;
         held    = 0;
         credit  = int'(BUDGET_RESET);
         idle    = 1'b1;
         fails   = 0;
         checked = 0;
      endfunction

      function int ring_step(int idx);
         return (idx < QUEUE_DEPTH - 1) ? idx + 1 : 0;
      endfunction

      // returned bytes saturate at the top of the credit range
      function void return_bytes(int bytes);
         credit = (credit + bytes > int'(CREDIT_MAX)) ? int'(CREDIT_MAX) : credit + bytes;
      endfunction

      function void load_budget(logic [15:0] value);
         credit = int'(value);
      endfunction

      function int pending();
         return due_results.size();
      endfunction

      // a completion that would start a descriptor from a slot never filled
      function bit done_reads_blank();
         if (!slot_held[tail]) return 1'b0;
         return (held - 1 > 0) && !slot_written[ring_step(tail)];
      endfunction

      function void note_command(req_type cmd);
         rsp_type want;
         int      left;
         want = '0;
         want.status = ST_OK;
         case (cmd.mode)
            MODE_WRITE: begin
               left = credit - int'(cmd.packet_size);
               if (held >= QUEUE_DEPTH || left <= 0) begin
                  want.status = ST_REFUSED;
               end else begin
                  // charged even when the head slot turns out to be taken
                  credit = left;
                  if (slot_held[head]) begin
                     want.status = ST_OCCUPIED;
                  end else begin
                     slot_port[head]    = cmd.port;
                     slot_len[head]     = cmd.packet_size;
                     slot_held[head]    = 1'b1;
                     slot_written[head] = 1'b1;
                     held++;
                     head = ring_step(head);
                     if (idle) begin
                        if (cmd.port != 2'd0) begin
                           want.start_valid = 1'b1;
                           want.start_port  = cmd.port;
                           want.start_size  = cmd.packet_size;
                           idle = 1'b0;
                        end else begin
                           want.status = ST_BAD_PORT;
                        end
                     end
                  end
               end
            end
            MODE_DONE: begin
               if (slot_held[tail]) begin
                  if (held > 0) held--;
                  return_bytes(int'(slot_len[tail]));
                  slot_held[tail] = 1'b0;
                  tail = ring_step(tail);
                  want.sent_event = 1'b1;
                  if (held > 0) begin
                     // next descriptor goes out as stored, port 0 included
                     want.start_valid = 1'b1;
                     want.start_port  = slot_port[tail];
                     want.start_size  = slot_len[tail];
                  end else begin
                     idle = 1'b1;
                  end
               end else begin
                  want.status = ST_FREE_FAIL;
                  tail = ring_step(tail);
               end
            end
            MODE_CLEAR: begin
               held = 0;
               foreach (slot_held[i]) begin
                  if (slot_held[i]) begin
                     return_bytes(int'(slot_len[i]));
                     slot_held[i] = 1'b0;
                  end
               end
               head = 0;
               tail = 0;
               want.status = ST_CLEARED;
            end
            MODE_NONE: ;
         endcase
         want.queue_count = 9'(held);
         want.link_idle   = idle;
         want.credit_left = 16'(credit);
         status_seen[want.status]++;
         due_results.push_back(want);
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (due_results.size() == 0) begin
            fails++;
            if (fails <= 10)
               $display("%0t: result with nothing expected, status %0d credit %0d",
                        $time, got.status, got.credit_left);
            return;
         end
         want = due_results.pop_front();
         checked++;
         if (got !== want) begin
            fails++;
            if (fails <= 10) begin
               $display("%0t: mismatch (expected/actual) status %0d/%0d count %0d/%0d",
                        $time, want.status, got.status, want.queue_count, got.queue_count);
               $display("   start %b/%b port %0d/%0d size %0d/%0d sent %b/%b idle %b/%b",
                        want.start_valid, got.start_valid, want.start_port, got.start_port,
                        want.start_size, got.start_size, want.sent_event, got.sent_event,
                        want.link_idle, got.link_idle);
               $display("   credit %0d/%0d", want.credit_left, got.credit_left);
            end
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        start;
   logic        busy;
   req_type     req_item;
   logic        rsp_strobe;
   rsp_type     rsp_item;
   logic        csr_write_en;
   logic [15:0] csr_write_data;

   descriptor_ring_scoreboard sb;
   int budget_writes = 0;

   always #4 clock = ~clock;

   tx_descriptor_queue_with_byte_credit #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) i_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_item      (req_item),
      .rsp_strobe    (rsp_strobe),
      .rsp_item      (rsp_item),
      .csr_write_en  (csr_write_en),
      .csr_write_data(csr_write_data)
   );

   // results cannot be held off, so every strobe is taken at the edge ending it
   always @(posedge clock) begin
      if (!reset && rsp_strobe) sb.check_result(rsp_item);
   end

   function automatic req_type make_cmd(logic [1:0] mode, logic [1:0] port,
                                        logic [15:0] size);
      req_type c;
      c.mode        = mode;
      c.port        = port;
      c.packet_size = size;
      return c;
   endfunction

   // mostly small packets, with the range ends and the exact-credit boundary
   function automatic logic [15:0] pick_size();
      case ($urandom_range(11))
         0:       return 16'd0;
         1:       return 16'hFFFF;
         2:       return 16'($urandom);
         3:       return 16'(sb.credit);
         4:       return 16'(sb.credit - 1);
         default: return 16'($urandom_range(1, 400));
      endcase
   endfunction

   function automatic req_type pick_command(int write_pct);
      int      r;
      req_type c;
      r = $urandom_range(99);
      if (r < write_pct)
         c = make_cmd(MODE_WRITE, 2'($urandom_range(3)), pick_size());
      else if (r < 94)
         c = make_cmd(MODE_DONE, 2'($urandom), 16'($urandom));
      else if (r < 98)
         c = make_cmd(MODE_CLEAR, 2'($urandom), 16'($urandom));
      else
         c = make_cmd(MODE_NONE, 2'($urandom), 16'($urandom));
      // never let a completion start from a slot that holds no data yet
      if (c.mode == MODE_DONE && sb.done_reads_blank()) begin
         c.mode        = MODE_WRITE;
         c.packet_size = pick_size();
      end
      return c;
   endfunction

   // hold start high until the transfer is taken; start is left high
   task automatic send_command(input req_type cmd);
      req_item <= cmd;
      start    <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_command(cmd);
   endtask

   task automatic drain();
      while (sb.pending() > 0) @(posedge clock);
   endtask

   // only called with start low and nothing outstanding
   task automatic write_budget(input logic [15:0] value);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      sb.load_budget(value);
      budget_writes++;
   endtask

   initial begin
      int          write_pct;
      int          burst_left;
      int          per_phase;
      bit          hold;
      logic [15:0] budget;

      sb             = new();
      reset          = 1'b1;
      start          = 1'b0;
      req_item       = '0;
      csr_write_en   = 1'b0;
      csr_write_data = '0;
      per_phase      = RANDOM_ITEMS / PHASES;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed part, from the reset budget
      send_command(make_cmd(MODE_NONE, 2'd3, 16'hFFFF));      // unused mode
      send_command(make_cmd(MODE_DONE, 2'd0, 16'd0));         // completion on empty slot
      send_command(make_cmd(MODE_WRITE, 2'd0, 16'd10));       // port 0 while idle
      send_command(make_cmd(MODE_WRITE, 2'd3, 16'hFFFF));     // far over credit
      send_command(make_cmd(MODE_WRITE, 2'd2, 16'(sb.credit))); // would leave exactly zero
      send_command(make_cmd(MODE_WRITE, 2'd1, 16'd100));      // starts the link
      send_command(make_cmd(MODE_WRITE, 2'd2, 16'd0));        // zero length, queued
      send_command(make_cmd(MODE_DONE, 2'd1, 16'd1));         // free and start next
      // fill the rest of the ring so head wraps onto the still occupied slot 0
      for (int i = 0; i < 13; i++)
         send_command(make_cmd(MODE_WRITE, 2'($urandom_range(3)),
                               16'($urandom_range(1, 300))));
      send_command(make_cmd(MODE_WRITE, 2'd1, 16'd50));       // occupied head slot
      send_command(make_cmd(MODE_CLEAR, 2'd0, 16'd0));        // link stays busy
      send_command(make_cmd(MODE_WRITE, 2'd2, 16'd1));        // queued, no start
      send_command(make_cmd(MODE_DONE, 2'd0, 16'd0));         // last one, back to idle
      start <= 1'b0;
      drain();

      // random phases, each under its own budget
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase % 6)
            0:       budget = 16'hFFFF;
            1:       budget = 16'd1;
            2:       budget = BUDGET_RESET;
            3:       budget = 16'($urandom_range(1, 65535));
            4:       budget = 16'($urandom_range(200, 3000));
            default: budget = 16'($urandom_range(3000, 12000));
         endcase
         write_budget(budget);
         write_pct  = $urandom_range(25, 85);
         burst_left = $urandom_range(1, 24);
         for (int k = 0; k < per_phase; k++) begin
            send_command(pick_command(write_pct));
            burst_left--;
            hold = ($urandom_range(99) < 2);
            if (k == per_phase - 1 || hold) begin
               // wait for every outstanding result before going on
               start <= 1'b0;
               drain();
               burst_left = $urandom_range(1, 24);
            end else if (burst_left == 0) begin
               start <= 1'b0;
               repeat ($urandom_range(1, 12)) @(posedge clock);
               burst_left = $urandom_range(1, 24);
            end
         end
      end

      drain();
      repeat (QUEUE_DEPTH + 8) @(posedge clock);
      if (sb.pending() != 0) sb.fails++;

      $display("covered %0d results under %0d budget loads: %0d ok, %0d refused, %0d head taken",
               sb.checked, budget_writes, sb.status_seen[ST_OK], sb.status_seen[ST_REFUSED],
               sb.status_seen[ST_OCCUPIED]);
      $display("also %0d frees on empty slots, %0d port 0 while idle, %0d clears, %0d failures",
               sb.status_seen[ST_FREE_FAIL], sb.status_seen[ST_BAD_PORT],
               sb.status_seen[ST_CLEARED], sb.fails);
      if (sb.fails == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // guard against a hung handshake
   initial begin
      #5000000;
      $display("FAIL");
      $finish;
   end

endmodule
